// ----- src/biq_pkg.sv -----
// Package for the biquad low-pass filter: coefficient types, register
// indexes and default parameter values. Depends on nothing.
`timescale 1ns / 1ps

package biq_pkg;

   localparam int COEF_WIDTH      = 19;
   localparam int FRAC_BITS       = 16;
   localparam int NUM_COEFS       = 5;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int DEFAULT_WARMUP_SAMPLES = 500;
   localparam int DEFAULT_SAMPLE_WIDTH   = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_B2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_A1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_A2 = 3'd4;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
   } coef_set_type;

endpackage

// ----- src/biq_csr.sv -----
// Coefficient register file for the biquad filter, written through the
// plain write port. Depends on biq_pkg.
`timescale 1ns / 1ps

module biq_csr
   import biq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata,
   output coef_set_type               coefs
);

   coef_set_type coef_ff;
   coef_set_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_COEF_B0: coef_in.b0 = csr_wdata;
            REG_COEF_B1: coef_in.b1 = csr_wdata;
            REG_COEF_B2: coef_in.b2 = csr_wdata;
            REG_COEF_A1: coef_in.a1 = csr_wdata;
            REG_COEF_A2: coef_in.a2 = csr_wdata;
            default:     coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coefs = coef_ff;

endmodule

// ----- src/biq_filter.sv -----
// Single-pass biquad arithmetic: five products, full-precision sum,
// round half up and saturate to the sample width. Depends on biq_pkg.
`timescale 1ns / 1ps

module biq_filter
   import biq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEFAULT_SAMPLE_WIDTH
) (
   input  coef_set_type                   coefs,
   input  logic signed [SAMPLE_WIDTH-1:0] x0,
   input  logic signed [SAMPLE_WIDTH-1:0] x1,
   input  logic signed [SAMPLE_WIDTH-1:0] x2,
   input  logic signed [SAMPLE_WIDTH-1:0] y1,
   input  logic signed [SAMPLE_WIDTH-1:0] y2,
   output logic signed [SAMPLE_WIDTH-1:0] y0
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_W  = PROD_W + 4;
   localparam int RES_W  = ACC_W - FRAC_BITS;

   localparam logic signed [RES_W-1:0] SAT_HI =
      {{(RES_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [RES_W-1:0] SAT_LO =
      {{(RES_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] HALF_LSB =
      {{(ACC_W-FRAC_BITS+1){1'b0}}, {(FRAC_BITS-1){1'b0}}} | (ACC_W'(1) << (FRAC_BITS-1));

   logic signed [PROD_W-1:0] prod_b0;
   logic signed [PROD_W-1:0] prod_b1;
   logic signed [PROD_W-1:0] prod_b2;
   logic signed [PROD_W-1:0] prod_a1;
   logic signed [PROD_W-1:0] prod_a2;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  acc_rnd;
   logic signed [RES_W-1:0]  res;

   always_comb begin
      prod_b0 = PROD_W'($signed(coefs.b0) * x0);
      prod_b1 = PROD_W'($signed(coefs.b1) * x1);
      prod_b2 = PROD_W'($signed(coefs.b2) * x2);
      prod_a1 = PROD_W'($signed(coefs.a1) * y1);
      prod_a2 = PROD_W'($signed(coefs.a2) * y2);

      acc = ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
          - ACC_W'(prod_a1) - ACC_W'(prod_a2);

      acc_rnd = acc + HALF_LSB;
      res     = $signed(acc_rnd[ACC_W-1:FRAC_BITS]);

      if (res > SAT_HI) begin
         y0 = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (res < SAT_LO) begin
         y0 = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         y0 = res[SAMPLE_WIDTH-1:0];
      end
   end

endmodule

// ----- src/biquad_lowpass_with_warmup.sv -----
// Top level of the biquad low-pass filter with warm-up pass-through.
// Depends on biq_pkg, biq_csr and biq_filter.
//
// Second-order IIR low-pass filter, direct form I, one sample per
// transaction. The block accepts one transaction every clock cycle
// unless rsp_ready holds the output side, and passes each one through
// one input register, then the filter arithmetic, then the result
// register to the rsp_ ports. The rate is set by the feedback path from
// the output delay registers through five parallel multipliers and one
// adder back into those registers, which is combinational. For the first
// WARMUP_SAMPLES samples after reset the input is passed through and
// rsp_warming_up is high; the delay lines advance on every sample.
// Coefficients are signed Q3.16, reset to zero, and should be written
// while no transaction is in flight.
`timescale 1ns / 1ps

module biquad_lowpass_with_warmup
   import biq_pkg::*;
#(
   parameter int WARMUP_SAMPLES = DEFAULT_WARMUP_SAMPLES,
   parameter int SAMPLE_WIDTH   = DEFAULT_SAMPLE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_WIDTH-1:0]    req_sample_in,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]    rsp_sample_out,
   output logic                       rsp_warming_up,

   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata
);

   localparam int CNT_W = (WARMUP_SAMPLES > 0) ? $clog2(WARMUP_SAMPLES + 1) : 1;
   localparam logic [CNT_W-1:0] WARMUP_LIMIT = CNT_W'(WARMUP_SAMPLES);

   coef_set_type coefs;

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;

   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic [SAMPLE_WIDTH-1:0]        out_sample_ff;
   logic                           out_warm_ff;

   logic signed [SAMPLE_WIDTH-1:0] x1_ff;
   logic signed [SAMPLE_WIDTH-1:0] x2_ff;
   logic signed [SAMPLE_WIDTH-1:0] y1_ff;
   logic signed [SAMPLE_WIDTH-1:0] y2_ff;
   logic [CNT_W-1:0]               warmup_count_ff;
   logic [CNT_W-1:0]               warmup_count_in;

   logic                           req_accept;
   logic                           advance;
   logic                           warming;
   logic signed [SAMPLE_WIDTH-1:0] filtered;
   logic signed [SAMPLE_WIDTH-1:0] y_next;

   biq_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .coefs            (coefs)
   );

   biq_filter #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_filter (
      .coefs (coefs),
      .x0    (in_sample_ff),
      .x1    (x1_ff),
      .x2    (x2_ff),
      .y1    (y1_ff),
      .y2    (y2_ff),
      .y0    (filtered)
   );

   always_comb begin
      advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready  = !in_valid_ff || advance;
      req_accept = req_valid && req_ready;

      warming = warmup_count_ff < WARMUP_LIMIT;
      y_next  = warming ? in_sample_ff : filtered;

      warmup_count_in = warmup_count_ff;
      if (advance && warming) begin
         warmup_count_in = warmup_count_ff + CNT_W'(1);
      end

      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         x1_ff           <= '0;
         x2_ff           <= '0;
         y1_ff           <= '0;
         y2_ff           <= '0;
         warmup_count_ff <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         warmup_count_ff <= warmup_count_in;
         if (advance) begin
            x1_ff <= in_sample_ff;
            x2_ff <= x1_ff;
            y1_ff <= y_next;
            y2_ff <= y1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_sample_ff <= req_sample_in;
      end
      if (advance) begin
         out_sample_ff <= y_next;
         out_warm_ff   <= warming;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_warming_up = out_warm_ff;

endmodule
